@@ sv/rgs_pkg.sv @@
// Shared types and codes for the run-length glyph span rasterizer.
package rgs_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] OP_SET_PEN = 2'd0;
   localparam logic [1:0] OP_SPACE   = 2'd1;
   localparam logic [1:0] OP_GLYPH   = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_INTER_CHAR_SPACE = 3'd0;
   localparam logic [2:0] REG_SPACE_WIDTH      = 3'd1;
   localparam logic [2:0] REG_TEXT_COLOR       = 3'd2;
   localparam logic [2:0] REG_CLIP_LEFT        = 3'd3;
   localparam logic [2:0] REG_CLIP_RIGHT       = 3'd4;
   localparam logic [2:0] REG_CLIP_TOP         = 3'd5;
   localparam logic [2:0] REG_CLIP_BOTTOM      = 3'd6;

   localparam logic [9:0] CLIP_RIGHT_RESET  = 10'd640;
   localparam logic [8:0] CLIP_BOTTOM_RESET = 9'd480;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   typedef struct packed {
      logic [8:0] row;
      logic [9:0] column;
      logic [9:0] length;
      logic [7:0] color;
   } span_type;

   typedef struct packed {
      logic [9:0] left;
      logic [9:0] right;
      logic [8:0] top;
      logic [8:0] bottom;
      logic [7:0] color;
   } clip_type;

endpackage

@@ sv/rgs_span_clip.sv @@
// Clips one fill run against the window and forms the span.
module rgs_span_clip #(
   parameter int COORD_BITS = 16
) (
   input  logic [COORD_BITS-1:0] cursor_x,
   input  logic [COORD_BITS-1:0] cursor_y,
   input  logic [7:0]            fill_count,
   input  rgs_pkg::clip_type     clip,
   output logic                  visible,
   output rgs_pkg::span_type     span
);
   import rgs_pkg::*;

   // two spare bits: start plus a byte never wraps, and clip values fit unsigned
   localparam int W = COORD_BITS + 2;

   logic signed [W-1:0] start;
   logic signed [W-1:0] stop;
   logic signed [W-1:0] row;
   logic signed [W-1:0] left;
   logic signed [W-1:0] right;
   logic signed [W-1:0] top;
   logic signed [W-1:0] bottom;
   logic signed [W-1:0] lo;
   logic signed [W-1:0] hi;
   logic signed [W-1:0] len;

   always_comb begin
      start  = W'(signed'(cursor_x));
      row    = W'(signed'(cursor_y));
      stop   = start + signed'(W'(fill_count));
      left   = signed'(W'(clip.left));
      right  = signed'(W'(clip.right));
      top    = signed'(W'(clip.top));
      bottom = signed'(W'(clip.bottom));
      lo     = (start > left) ? start : left;
      hi     = (stop < right) ? stop : right;
      len    = hi - lo;

      visible = (fill_count != 8'd0) && (lo < hi) && (row >= top) && (row < bottom);

      span.row    = row[8:0];
      span.column = lo[9:0];
      span.length = len[9:0];
      span.color  = clip.color;
   end

endmodule

@@ sv/rle_glyph_span_rasterizer_top.sv @@
// Run-length glyph span rasterizer: top level with pen, glyph decoder and result register.
// A span appears on rsp_tvalid in the cycle after its fill byte request is accepted.
// Throughput: one request per cycle unless a span waits on rsp_tready; the decode and
// clip sit between the request handshake and the single result register, freed when taken.
// Reset (synchronous): config returns to 0,0,0,0,640,0,480, decoder waits for a
// glyph width, pen and cursors go to zero and no result is pending.
module rle_glyph_span_rasterizer_top #(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pen_x[15:0], pen_y[31:16], data_byte[39:32]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // span_row[8:0], span_column[18:9],
                                    // span_length[28:19], span_color[36:29], zero[39:37]
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_write_data
);
   import rgs_pkg::*;

   localparam logic [2:0] PH_WIDTH  = 3'd0;
   localparam logic [2:0] PH_HEIGHT = 3'd1;
   localparam logic [2:0] PH_XOFF   = 3'd2;
   localparam logic [2:0] PH_YOFF   = 3'd3;
   localparam logic [2:0] PH_COUNT  = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;
   localparam logic [2:0] PH_FILL   = 3'd6;

   // configuration
   logic [7:0] gap_ff, space_ff;
   clip_type   clip_ff;

   // decoder state
   logic [2:0]            phase_ff, phase_in;
   logic [7:0]            glyph_width_ff, glyph_width_in;
   logic [7:0]            rows_left_ff, rows_left_in;
   logic [7:0]            entries_left_ff, entries_left_in;
   logic [COORD_BITS-1:0] row_origin_x_ff, row_origin_x_in;
   logic [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [COORD_BITS-1:0] pen_col_ff, pen_col_in;
   logic [COORD_BITS-1:0] pen_row_ff, pen_row_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   span_type rsp_span_ff, rsp_span_in;

   logic                  req_fire;
   logic                  glyph_fire;
   logic [1:0]            opcode;
   logic signed [15:0]    pen_x_req, pen_y_req;
   logic [7:0]            data_byte;
   logic [7:0]            entries_dec, rows_dec;
   logic [COORD_BITS-1:0] cursor_x_step;
   logic                  span_visible;
   span_type              span;

   assign opcode    = req_tuser;
   assign pen_x_req = signed'(req_tdata[15:0]);
   assign pen_y_req = signed'(req_tdata[31:16]);
   assign data_byte = req_tdata[39:32];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign glyph_fire = req_fire && (opcode == OP_GLYPH);

   rgs_span_clip #(
      .COORD_BITS (COORD_BITS)
   ) u_clip (
      .cursor_x   (cursor_x_ff),
      .cursor_y   (cursor_y_ff),
      .fill_count (data_byte),
      .clip       (clip_ff),
      .visible    (span_visible),
      .span       (span)
   );

   always_comb begin
      phase_in        = phase_ff;
      glyph_width_in  = glyph_width_ff;
      rows_left_in    = rows_left_ff;
      entries_left_in = entries_left_ff;
      row_origin_x_in = row_origin_x_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      pen_col_in      = pen_col_ff;
      pen_row_in      = pen_row_ff;

      entries_dec   = entries_left_ff - 8'd1;
      rows_dec      = rows_left_ff - 8'd1;
      cursor_x_step = cursor_x_ff + COORD_BITS'(data_byte);

      if (req_fire) begin
         unique case (opcode)
            OP_SET_PEN: begin
               pen_col_in = COORD_BITS'(pen_x_req);
               pen_row_in = COORD_BITS'(pen_y_req);
            end
            OP_SPACE: begin
               pen_col_in = pen_col_ff + COORD_BITS'(space_ff);
            end
            OP_GLYPH: begin
               unique case (phase_ff)
                  PH_WIDTH: begin
                     glyph_width_in = data_byte;
                     phase_in       = PH_HEIGHT;
                  end
                  PH_HEIGHT: begin
                     rows_left_in = data_byte;
                     phase_in     = PH_XOFF;
                  end
                  PH_XOFF: begin
                     row_origin_x_in = pen_col_ff + COORD_BITS'(data_byte);
                     cursor_x_in     = pen_col_ff + COORD_BITS'(data_byte);
                     phase_in        = PH_YOFF;
                  end
                  PH_YOFF: begin
                     cursor_y_in = pen_row_ff + COORD_BITS'(data_byte);
                     phase_in    = PH_COUNT;
                  end
                  PH_COUNT: begin
                     entries_left_in = data_byte;
                     phase_in        = PH_SKIP;
                  end
                  PH_SKIP, PH_FILL: begin
                     entries_left_in = entries_dec;
                     if (entries_dec != 8'd0) begin
                        cursor_x_in = cursor_x_step;
                        phase_in    = (phase_ff == PH_SKIP) ? PH_FILL : PH_SKIP;
                     end else begin
                        // row done: back to the row origin, one row down
                        cursor_x_in  = row_origin_x_ff;
                        cursor_y_in  = cursor_y_ff + COORD_BITS'(1);
                        rows_left_in = rows_dec;
                        if (rows_dec == 8'd0) begin
                           pen_col_in = pen_col_ff + COORD_BITS'(glyph_width_ff)
                                        + COORD_BITS'(gap_ff);
                           phase_in   = PH_WIDTH;
                        end else begin
                           phase_in = PH_COUNT;
                        end
                     end
                  end
                  default: phase_in = PH_WIDTH;
               endcase
            end
            default: ;
         endcase
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_span_in  = rsp_span_ff;
      if (req_fire) begin
         rsp_valid_in = glyph_fire && (phase_ff == PH_FILL) && span_visible;
         rsp_span_in  = span;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff         <= '0;
         space_ff       <= '0;
         clip_ff.color  <= '0;
         clip_ff.left   <= '0;
         clip_ff.right  <= CLIP_RIGHT_RESET;
         clip_ff.top    <= '0;
         clip_ff.bottom <= CLIP_BOTTOM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_INTER_CHAR_SPACE: gap_ff         <= csr_write_data[7:0];
            REG_SPACE_WIDTH:      space_ff       <= csr_write_data[7:0];
            REG_TEXT_COLOR:       clip_ff.color  <= csr_write_data[7:0];
            REG_CLIP_LEFT:        clip_ff.left   <= csr_write_data;
            REG_CLIP_RIGHT:       clip_ff.right  <= csr_write_data;
            REG_CLIP_TOP:         clip_ff.top    <= csr_write_data[8:0];
            REG_CLIP_BOTTOM:      clip_ff.bottom <= csr_write_data[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WIDTH;
         glyph_width_ff  <= '0;
         rows_left_ff    <= '0;
         entries_left_ff <= '0;
         row_origin_x_ff <= '0;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         pen_col_ff      <= '0;
         pen_row_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         glyph_width_ff  <= glyph_width_in;
         rows_left_ff    <= rows_left_in;
         entries_left_ff <= entries_left_in;
         row_origin_x_ff <= row_origin_x_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         pen_col_ff      <= pen_col_in;
         pen_row_ff      <= pen_row_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_span_ff <= rsp_span_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_span_ff.color, rsp_span_ff.length,
                        rsp_span_ff.column, rsp_span_ff.row};

   // pen and space requests never produce a span
   a_no_span_from_pen: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (opcode != OP_GLYPH)) |=> !rsp_valid_ff)
      else $error("span produced by a pen request");

   // a span only follows a fill byte
   a_span_from_fill: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !((opcode == OP_GLYPH) && (phase_ff == PH_FILL))) |=> !rsp_valid_ff)
      else $error("span produced outside a fill byte");

   a_span_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_span_ff.length != 10'd0))
      else $error("empty span delivered");

   a_header_order: assert property (@(posedge clock) disable iff (reset)
      (glyph_fire && (phase_ff == PH_WIDTH)) |=> (phase_ff == PH_HEIGHT))
      else $error("glyph width not followed by height");

endmodule

@@ tb/sv/rle_glyph_span_rasterizer_top_tb.sv @@
// Testbench for the glyph span rasterizer: random glyph streams checked against a span predictor.
`timescale 1ns / 100ps

module rle_glyph_span_rasterizer_top_tb;
   import rgs_pkg::*;

   localparam int COORD_BITS  = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_BUDGET = 1750;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      PH_WIDTH, PH_HEIGHT, PH_XOFF, PH_YOFF, PH_COUNT, PH_SKIP, PH_FILL
   } decode_phase_type;

   // Mirrors the pen, the glyph decoder and the clip window; holds the spans still owed.
   class span_predictor;
      logic [7:0] gap_px, space_px, color;
      logic [9:0] clip_l, clip_r;
      logic [8:0] clip_t, clip_b;
      decode_phase_type phase;
      logic [7:0] glyph_w, rows_left, entries_left;
      logic signed [COORD_BITS-1:0] origin_x, cur_x, cur_y, pen_x, pen_y;
      span_type expected_spans[$];
      int errors;

      function new();
         gap_px = '0; space_px = '0; color = '0;
         clip_l = '0; clip_r = CLIP_RIGHT_RESET;
         clip_t = '0; clip_b = CLIP_BOTTOM_RESET;
         phase = PH_WIDTH;
         glyph_w = '0; rows_left = '0; entries_left = '0;
         origin_x = '0; cur_x = '0; cur_y = '0; pen_x = '0; pen_y = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [9:0] value);
         case (idx)
            REG_INTER_CHAR_SPACE: gap_px = value[7:0];
            REG_SPACE_WIDTH:      space_px = value[7:0];
            REG_TEXT_COLOR:       color = value[7:0];
            REG_CLIP_LEFT:        clip_l = value;
            REG_CLIP_RIGHT:       clip_r = value;
            REG_CLIP_TOP:         clip_t = value[8:0];
            REG_CLIP_BOTTOM:      clip_b = value[8:0];
            default: ;
         endcase
      endfunction

      function void end_entry();
         entries_left = entries_left - 8'd1;
         if (entries_left != 8'd0) begin
            phase = (phase == PH_SKIP) ? PH_FILL : PH_SKIP;
            return;
         end
         cur_y = cur_y + COORD_BITS'(1);
         cur_x = origin_x;
         rows_left = rows_left - 8'd1;
         if (rows_left == 8'd0) begin
            // pen advance uses the pen as it stands now, even if moved mid glyph
            pen_x = pen_x + COORD_BITS'(glyph_w) + COORD_BITS'(gap_px);
            phase = PH_WIDTH;
         end else begin
            phase = PH_COUNT;
         end
      endfunction

      function void note_request(logic [1:0] op, logic [15:0] px, logic [15:0] py,
                                 logic [7:0] b);
         int start_col, stop_col, row_i, run, lo, hi, lim;
         span_type s;
         case (op)
            OP_SET_PEN: begin
               pen_x = px[COORD_BITS-1:0];
               pen_y = py[COORD_BITS-1:0];
            end
            OP_SPACE: pen_x = pen_x + COORD_BITS'(space_px);
            OP_GLYPH: begin
               case (phase)
                  PH_WIDTH: begin glyph_w = b; phase = PH_HEIGHT; end
                  PH_HEIGHT: begin rows_left = b; phase = PH_XOFF; end
                  PH_XOFF: begin
                     origin_x = pen_x + COORD_BITS'(b);
                     cur_x = origin_x;
                     phase = PH_YOFF;
                  end
                  PH_YOFF: begin cur_y = pen_y + COORD_BITS'(b); phase = PH_COUNT; end
                  PH_COUNT: begin entries_left = b; phase = PH_SKIP; end
                  PH_SKIP: begin
                     cur_x = cur_x + COORD_BITS'(b);
                     end_entry();
                  end
                  default: begin
                     start_col = int'(cur_x);
                     run = int'(b);
                     stop_col = start_col + run;
                     row_i = int'(cur_y);
                     lim = int'(clip_l);
                     lo = (start_col > lim) ? start_col : lim;
                     lim = int'(clip_r);
                     hi = (stop_col < lim) ? stop_col : lim;
                     if (run != 0 && lo < hi && row_i >= int'(clip_t)
                         && row_i < int'(clip_b)) begin
                        s.row = row_i[8:0];
                        s.column = lo[9:0];
                        s.length = 10'(hi - lo);
                        s.color = color;
                        expected_spans.push_back(s);
                     end
                     cur_x = stop_col[COORD_BITS-1:0];
                     end_entry();
                  end
               endcase
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_span(logic [39:0] d);
         span_type want;
         if (expected_spans.size() == 0) begin
            $display("%0t: unexpected span: expected none, actual row %0d col %0d len %0d color %0d",
                     $time, d[8:0], d[18:9], d[28:19], d[36:29]);
            errors++;
            return;
         end
         want = expected_spans.pop_front();
         compare_field("span_row", int'(want.row), int'(d[8:0]));
         compare_field("span_column", int'(want.column), int'(d[18:9]));
         compare_field("span_length", int'(want.length), int'(d[28:19]));
         compare_field("span_color", int'(want.color), int'(d[36:29]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // pen_x[15:0], pen_y[31:16], data_byte[39:32]
   logic [1:0]  req_tuser = OP_SET_PEN;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // span_row[8:0], span_column[18:9], span_length[28:19],
                             // span_color[36:29]
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = REG_INTER_CHAR_SPACE;
   logic [9:0]  csr_write_data = '0;

   span_predictor glyph_spans = new();
   int  requests_sent = 0;
   int  burst_left = 0;
   bit  no_gaps = 1'b0;
   bit  noise_on = 1'b0;
   bit  hold_results = 1'b0;
   int  quiet_cycles = 0;

   rle_glyph_span_rasterizer_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // check before noting: a span never leaves in the cycle its request enters
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) glyph_spans.check_span(rsp_tdata);
         if (req_tvalid && req_tready)
            glyph_spans.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16],
                                     req_tdata[39:32]);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // span receiver: rotating stall patterns, plus one long hold-off on request
   initial begin
      int cyc;
      logic [7:0] pattern;
      cyc = 0;
      pattern = 8'b1011_0010;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            case ((cyc / 97) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: begin
                  pattern = {pattern[6:0], pattern[7]};
                  rsp_tready <= pattern[0];
               end
            endcase
            cyc++;
         end
      end
   end

   task automatic put_request(input logic [1:0] op, input logic [15:0] px,
                              input logic [15:0] py, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0 && !no_gaps) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, py, px};
      do @(posedge clock); while (!req_tready);
      if (op != OP_UNUSED) requests_sent++;
   endtask

   task automatic place_pen();
      int x, y;
      x = $urandom_range(0, 800) - 100;
      y = $urandom_range(0, 540) - 30;
      put_request(OP_SET_PEN, x[15:0], y[15:0], 8'($urandom));
   endtask

   // glyph byte, with an occasional stray pen command or unused opcode ahead of it
   task automatic put_byte(input logic [7:0] b);
      if (noise_on && $urandom_range(0, 24) == 0) begin
         case ($urandom_range(0, 3))
            0: put_request(OP_SPACE, 16'($urandom), 16'($urandom), 8'($urandom));
            1: put_request(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom));
            2: place_pen();
            default: put_request(OP_SET_PEN, 16'($urandom), 16'($urandom), 8'($urandom));
         endcase
      end
      put_request(OP_GLYPH, 16'($urandom), 16'($urandom), b);
   endtask

   function automatic logic [7:0] pick_byte();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 15));
   endfunction

   // kind 0: ordinary glyph, 1: zero height (256 rows), 2: first row with zero entry count
   task automatic send_glyph(input int kind);
      int rows, n;
      logic [7:0] height, cnt;
      height = (kind == 1) ? 8'd0 : 8'($urandom_range(1, 4));
      put_byte(8'($urandom_range(0, 255)));
      put_byte(height);
      put_byte(pick_byte());
      put_byte(pick_byte());
      rows = (height == 0) ? 256 : height;
      for (int r = 0; r < rows; r++) begin
         if (kind == 2 && r == 0) cnt = 8'd0;
         else if (kind == 1) cnt = 8'($urandom_range(1, 2));
         else cnt = 8'($urandom_range(1, 6));
         put_byte(cnt);
         n = (cnt == 0) ? 256 : cnt;
         for (int e = 0; e < n; e++) put_byte(pick_byte());
      end
   endtask

   // idle the request side until every owed span is out, then let the pipe drain
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (glyph_spans.expected_spans.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input int p);
      logic [9:0] vals[7];
      int lo, top;
      case (p)
         1: vals = '{10'd255, 10'd255, 10'd255, 10'd0, 10'd640, 10'd0, 10'd480};
         2: vals = '{10'd0, 10'd0, 10'd0, 10'd640, 10'd0, 10'd480, 10'd0};
         default: begin
            lo = $urandom_range(0, 600);
            top = $urandom_range(0, 400);
            vals[REG_INTER_CHAR_SPACE] = 10'($urandom_range(0, 255));
            vals[REG_SPACE_WIDTH] = 10'($urandom_range(0, 255));
            vals[REG_TEXT_COLOR] = 10'($urandom_range(0, 255));
            vals[REG_CLIP_LEFT] = 10'(lo);
            vals[REG_CLIP_RIGHT] = ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 640))
                                                                : 10'($urandom_range(lo, 640));
            vals[REG_CLIP_TOP] = 10'(top);
            vals[REG_CLIP_BOTTOM] = 10'($urandom_range(top, 480));
         end
      endcase
      for (int i = 0; i < 7; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= i[2:0];
         csr_write_data <= vals[i];
         @(posedge clock);
         glyph_spans.write_reg(i[2:0], vals[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int target, glyphs, kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pen extremes, every opcode, zero fill, right clip, pen moves inside a glyph
      put_request(OP_SET_PEN, 16'h8000, 16'h7FFF, 8'h00);
      put_request(OP_SET_PEN, 16'h7FFF, 16'h8000, 8'hFF);
      put_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
      put_request(OP_SPACE, 16'h0000, 16'h0000, 8'h00);
      put_request(OP_SET_PEN, 16'd10, 16'd20, 8'h00);
      put_byte(8'd255);
      put_byte(8'd2);
      put_byte(8'd255);
      put_byte(8'd255);
      put_byte(8'd4);
      put_byte(8'd0);
      put_byte(8'd0);
      put_byte(8'd5);
      put_byte(8'd255);
      put_request(OP_SPACE, 16'h0000, 16'h0000, 8'h00);
      put_request(OP_SET_PEN, 16'd100, 16'd400, 8'h00);
      put_byte(8'd2);
      put_byte(8'd255);
      put_byte(8'd255);
      // cursor wraps past the top of the coordinate range
      put_request(OP_SET_PEN, 16'd32760, 16'd0, 8'h00);
      put_byte(8'd0);
      put_byte(8'd1);
      put_byte(8'd10);
      put_byte(8'd0);
      put_byte(8'd2);
      put_byte(8'd0);
      put_byte(8'd20);

      noise_on = 1'b1;
      for (int p = 1; p <= 6; p++) begin
         settle();
         apply_settings(p);
         no_gaps = (p == 4);
         target = 26 + p * (ITEM_BUDGET - 26) / 6;
         glyphs = 0;
         while (requests_sent < target) begin
            if (p == 1 && glyphs == 2) hold_results = 1'b1;
            if (p == 3 && glyphs == 1) kind = 2;
            else if (p == 5 && glyphs == 1) kind = 1;
            else kind = 0;
            if ($urandom_range(0, 3) != 0) place_pen();
            if ($urandom_range(0, 9) == 0)
               put_request(OP_SPACE, 16'($urandom), 16'($urandom), 8'($urandom));
            send_glyph(kind);
            glyphs++;
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (glyph_spans.errors == 0 && glyph_spans.expected_spans.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ rle_glyph_span_rasterizer_top.f @@
sv/rgs_pkg.sv
sv/rgs_span_clip.sv
sv/rle_glyph_span_rasterizer_top.sv
tb/sv/rle_glyph_span_rasterizer_top_tb.sv
